/* src/plp_pkg.sv */
// Shared constants, codes and types of the positional list unit.
package plp_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int OP_W       = 4;
    localparam int DATA_W     = 32;
    localparam int POS_W      = 5;
    localparam int CNT_W      = 5;
    localparam int ST_W       = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_END   = 4'd1,
        OP_INS_POS   = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_DEL_END   = 4'd4,
        OP_DEL_POS   = 4'd5,
        OP_UNDO      = 4'd6,
        OP_REDO      = 4'd7,
        OP_READ      = 4'd8
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FULL    = 3'd3,
        ST_NO_UNDO = 3'd4,
        ST_NO_REDO = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_INS  = 2'd1,
        KIND_DEL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        SH_HOLD = 2'd0,
        SH_INS  = 2'd1,
        SH_DEL  = 2'd2
    } t_shift;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        t_shift              shift;
        logic [IDX_W-1:0]    at;
        logic [DATA_W-1:0]   value;
    } t_cell_cmd;

endpackage

/* src/plp_if.sv */
// Request and response channel interfaces of the positional list unit.
interface plp_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [plp_pkg::OP_W-1:0]             op;
    logic signed [plp_pkg::DATA_W-1:0]    value;
    logic [plp_pkg::POS_W-1:0]            position;

    modport source (output valid, op, value, position, input ready);
    modport sink (input valid, op, value, position, output ready);
endinterface

interface plp_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [plp_pkg::ST_W-1:0]             status;
    logic signed [plp_pkg::DATA_W-1:0]    result_value;
    logic [plp_pkg::POS_W-1:0]            result_position;
    logic [plp_pkg::CNT_W-1:0]            count;

    modport source (output valid, status, result_value, result_position, count, input ready);
    modport sink (input valid, status, result_value, result_position, count, output ready);
endinterface

/* src/positional_list_with_undo_unit.sv */
// Top level: ordered list with insert, delete, read and single-level undo/redo.
//
//  channel | dir | handshake      | payload
//  i_req   | in  | valid / ready  | op, value, position
//  o_rsp   | out | valid / ready  | status, result_value, result_position, count
//
// Each item is latched in the accept state (S_IDLE) and then decided in the execute
// state (S_EXEC), where the slots at and above the edit point shift by one in one step.
// The response sits in an output register; if it has not been taken, the
// execute cycle waits for it, and i_req.ready stays low until execution.
// Reset (synchronous, active low) clears the count and the undo record; entry
// contents are left alone, since only slots below the count are ever read.
module positional_list_with_undo_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plp_req_if.sink     i_req,
    plp_rsp_if.source   o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                             r_state;

    // latched request
    logic [plp_pkg::OP_W-1:0]           r_op;
    logic [plp_pkg::DATA_W-1:0]         r_value;
    logic [plp_pkg::POS_W-1:0]          r_pos;

    // list control and undo record
    logic [plp_pkg::CNT_W-1:0]          r_count;
    plp_pkg::t_kind                     r_last_kind;
    logic [plp_pkg::DATA_W-1:0]         r_last_value;
    logic [plp_pkg::CNT_W-1:0]          r_last_index;
    plp_pkg::t_kind                     r_undone_kind;

    // response register
    logic                               r_rsp_valid;
    logic [plp_pkg::ST_W-1:0]           r_status;
    logic [plp_pkg::DATA_W-1:0]         r_rvalue;
    logic [plp_pkg::POS_W-1:0]          r_rpos;
    logic [plp_pkg::CNT_W-1:0]          r_rcount;

    // decode
    plp_pkg::t_kind                     e_kind;
    logic [plp_pkg::CNT_W-1:0]          e_at;
    logic [plp_pkg::DATA_W-1:0]         e_val;
    plp_pkg::t_status                   e_pre_st;

    // decision
    plp_pkg::t_status                   st;
    logic [plp_pkg::DATA_W-1:0]         rv;
    logic [plp_pkg::POS_W-1:0]          rp;
    logic [plp_pkg::CNT_W-1:0]          new_count;
    logic                               is_ok;
    logic                               exec_fire;

    logic [plp_pkg::IDX_W-1:0]          rd_addr;
    logic [plp_pkg::DATA_W-1:0]         rd_data;
    logic [plp_pkg::DATA_W-1:0]         w_data [plp_pkg::LIST_DEPTH];
    plp_pkg::t_cell_cmd                 w_cmd;

    assign i_req.ready = (r_state == S_IDLE);
    assign exec_fire   = (r_state == S_EXEC) && (!r_rsp_valid || o_rsp.ready);

    // Translate the op into an edit on the list (kind, slot, value).
    // Undo applies the inverse of the recorded edit; redo re-applies it.
    always_comb begin
        e_kind   = plp_pkg::KIND_NONE;
        e_at     = '0;
        e_val    = r_value;
        e_pre_st = plp_pkg::ST_RANGE;
        case (r_op)
            plp_pkg::OP_INS_FRONT: begin
                e_kind = plp_pkg::KIND_INS;
            end
            plp_pkg::OP_INS_END: begin
                e_kind = plp_pkg::KIND_INS;
                e_at   = r_count;
            end
            plp_pkg::OP_INS_POS: begin
                e_kind = plp_pkg::KIND_INS;
                e_at   = r_pos;
            end
            plp_pkg::OP_DEL_FRONT: begin
                e_kind = plp_pkg::KIND_DEL;
            end
            plp_pkg::OP_DEL_END: begin
                e_kind = plp_pkg::KIND_DEL;
                e_at   = (r_count != '0) ? r_count - 1'b1 : '0;
            end
            plp_pkg::OP_DEL_POS: begin
                e_kind = plp_pkg::KIND_DEL;
                e_at   = r_pos;
            end
            plp_pkg::OP_UNDO: begin
                e_pre_st = plp_pkg::ST_NO_UNDO;
                e_at     = r_last_index;
                e_val    = r_last_value;
                if (r_last_kind == plp_pkg::KIND_INS) begin
                    e_kind = plp_pkg::KIND_DEL;
                end else if (r_last_kind == plp_pkg::KIND_DEL) begin
                    e_kind = plp_pkg::KIND_INS;
                end
            end
            plp_pkg::OP_REDO: begin
                e_pre_st = plp_pkg::ST_NO_REDO;
                e_at     = r_last_index;
                e_val    = r_last_value;
                e_kind   = r_undone_kind;
            end
            default: ;
        endcase
    end

    // Reads and deletes share one slot selector.
    assign rd_addr = (r_op == plp_pkg::OP_READ) ? r_pos[plp_pkg::IDX_W-1:0]
                                                 : e_at[plp_pkg::IDX_W-1:0];
    assign rd_data = w_data[rd_addr];

    // Check the edit against the list and form the response.
    always_comb begin
        st        = e_pre_st;
        rv        = '0;
        rp        = '0;
        new_count = r_count;
        if (e_kind == plp_pkg::KIND_INS) begin
            if (r_count >= plp_pkg::CNT_W'(plp_pkg::LIST_DEPTH)) begin
                st = plp_pkg::ST_FULL;
            end else if (e_at > r_count) begin
                st = plp_pkg::ST_RANGE;
            end else begin
                st        = plp_pkg::ST_OK;
                rv        = e_val;
                rp        = e_at;
                new_count = r_count + 1'b1;
            end
        end else if (e_kind == plp_pkg::KIND_DEL) begin
            if (r_count == '0) begin
                st = plp_pkg::ST_EMPTY;
            end else if (e_at >= r_count) begin
                st = plp_pkg::ST_RANGE;
            end else begin
                st        = plp_pkg::ST_OK;
                rv        = rd_data;
                rp        = e_at;
                new_count = r_count - 1'b1;
            end
        end else if (r_op == plp_pkg::OP_READ) begin
            if (r_count == '0) begin
                st = plp_pkg::ST_EMPTY;
            end else if (r_pos >= r_count) begin
                st = plp_pkg::ST_RANGE;
            end else begin
                st = plp_pkg::ST_OK;
                rv = rd_data;
                rp = r_pos;
            end
        end
    end

    assign is_ok = (st == plp_pkg::ST_OK);

    // Command for the chain: only a successful edit moves the slots.
    always_comb begin
        w_cmd.shift = plp_pkg::SH_HOLD;
        w_cmd.at    = e_at[plp_pkg::IDX_W-1:0];
        w_cmd.value = e_val;
        if (exec_fire && is_ok) begin
            if (e_kind == plp_pkg::KIND_INS) begin
                w_cmd.shift = plp_pkg::SH_INS;
            end else if (e_kind == plp_pkg::KIND_DEL) begin
                w_cmd.shift = plp_pkg::SH_DEL;
            end
        end
    end

    // Cell chain: slot g takes from g-1 on insert and from g+1 on delete.
    for (genvar g = 0; g < plp_pkg::LIST_DEPTH; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == plp_pkg::LIST_DEPTH - 1) ? g : g + 1;

        plp_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (plp_pkg::IDX_W'(g)),
            .i_left  (w_data[LEFT]),
            .i_right (w_data[RIGHT]),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_rsp_valid   <= 1'b0;
            r_count       <= '0;
            r_last_kind   <= plp_pkg::KIND_NONE;
            r_last_value  <= '0;
            r_last_index  <= '0;
            r_undone_kind <= plp_pkg::KIND_NONE;
        end else begin
            // a new response replaces the one taken in the same cycle
            if (o_rsp.ready && !exec_fire) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= i_req.op;
                        r_value <= i_req.value;
                        r_pos   <= i_req.position;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_state     <= S_IDLE;
                        r_rsp_valid <= 1'b1;
                        r_status    <= st;
                        r_rvalue    <= rv;
                        r_rpos      <= rp;
                        r_rcount    <= new_count;
                        r_count     <= new_count;
                        if (is_ok) begin
                            if (r_op == plp_pkg::OP_UNDO) begin
                                r_undone_kind <= r_last_kind;
                                r_last_kind   <= plp_pkg::KIND_NONE;
                            end else if (r_op == plp_pkg::OP_REDO) begin
                                r_last_kind   <= r_undone_kind;
                                r_undone_kind <= plp_pkg::KIND_NONE;
                            end else if (e_kind != plp_pkg::KIND_NONE) begin
                                r_last_kind   <= e_kind;
                                r_last_value  <= rv;
                                r_last_index  <= e_at;
                                r_undone_kind <= plp_pkg::KIND_NONE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid           = r_rsp_valid;
    assign o_rsp.status          = r_status;
    assign o_rsp.result_value    = r_rvalue;
    assign o_rsp.result_position = r_rpos;
    assign o_rsp.count           = r_rcount;

    // The list never holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plp_pkg::CNT_W'(plp_pkg::LIST_DEPTH))
        else $error("entry count above list depth");

    // An edit is either recorded for undo or recorded for redo, never both.
    a_record_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_last_kind != plp_pkg::KIND_NONE) && (r_undone_kind != plp_pkg::KIND_NONE)))
        else $error("undo and redo record both set");

    // An accepted item enters the execute state in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_EXEC))
        else $error("accepted item not in execution");

    // The count moves only in an execute cycle that fires.
    a_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec_fire |=> $stable(r_count))
        else $error("count changed outside execution");

endmodule

/* src/plp_cell.sv */
// One list slot: holds an entry and shifts with its neighbors on insert or delete.
module plp_cell (
    input  logic                           i_clk,
    input  plp_pkg::t_cell_cmd             i_cmd,
    input  logic [plp_pkg::IDX_W-1:0]      i_index,
    input  logic [plp_pkg::DATA_W-1:0]     i_left,
    input  logic [plp_pkg::DATA_W-1:0]     i_right,
    output logic [plp_pkg::DATA_W-1:0]     o_data
);

    logic [plp_pkg::DATA_W-1:0] r_data;
    logic [plp_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.shift)
            plp_pkg::SH_INS: begin
                if (i_index > i_cmd.at) begin
                    n_data = i_left;
                end else if (i_index == i_cmd.at) begin
                    n_data = i_cmd.value;
                end
            end
            plp_pkg::SH_DEL: begin
                if (i_index >= i_cmd.at) begin
                    n_data = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
